// ===== hdl/sahs_pkg.sv =====
package sahs_pkg;

    localparam int KEY_W = 64;
    localparam int VAL_W = 64;
    localparam int CFG_W = 9;

    typedef enum logic
    {
        KIND_ASSIGN = 1'b0,
        KIND_READ   = 1'b1
    } kind_t;

    typedef struct packed
    {
        logic             kind;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } item_t;

    typedef struct packed
    {
        logic [VAL_W-1:0] read_value;
        logic             status;
    } result_t;

endpackage

// ===== hdl/sahs_mod.sv =====
module sahs_mod #(
    parameter int BW          = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [63:0]   key,
    input  logic [BW:0]   modulus,
    output logic          done,
    output logic [BW-1:0] bucket
);
    import sahs_pkg::*;

    logic [63:0]   mag_reg;
    logic [BW:0]   rem_reg;
    logic [6:0]    cnt_reg;
    logic          busy_reg;
    logic          neg_reg;
    logic          done_reg;
    logic [BW-1:0] bucket_reg;
    logic [BW+1:0] trial;
    logic [BW:0]   fin;

    assign trial = {rem_reg, mag_reg[63]};
    assign fin   = (neg_reg && rem_reg != '0) ? modulus - rem_reg : rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
            neg_reg    <= 1'b0;
            mag_reg    <= '0;
            rem_reg    <= '0;
            bucket_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                neg_reg  <= key[63];
                mag_reg  <= key[63] ? (64'd0 - key) : key;
                rem_reg  <= '0;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                mag_reg <= {mag_reg[62:0], 1'b0};
                if (trial >= {1'b0, modulus})
                    rem_reg <= (BW+1)'(trial - {1'b0, modulus});
                else
                    rem_reg <= trial[BW:0];
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                begin
                    busy_reg <= 1'b0;
                end
            end
            else if (cnt_reg == 7'd64)
            begin
                done_reg   <= 1'b1;
                bucket_reg <= fin[BW-1:0];
                cnt_reg    <= '0;
            end
        end
    end

    assign done   = done_reg;
    assign bucket = bucket_reg;
endmodule

// ===== hdl/sahs_bank.sv =====
module sahs_bank #(
    parameter int MAX_BUCKETS = 256,
    parameter int WAYS        = 4,
    parameter int BW          = 8
) (
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic [BW-1:0]               rd_addr,
    output logic [WAYS-1:0][63:0]       rd_keys,
    output logic [WAYS-1:0][63:0]       rd_vals,
    output logic [WAYS-1:0]             rd_valid,
    input  logic                        wr_en,
    input  logic [BW-1:0]               wr_addr,
    input  logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] wr_way,
    input  logic [63:0]                 wr_key,
    input  logic [63:0]                 wr_val,
    input  logic                        vwr_en,
    input  logic [WAYS-1:0]             vwr_data
);
    import sahs_pkg::*;

    logic [WAYS-1:0][63:0] key_mem [MAX_BUCKETS];
    logic [WAYS-1:0][63:0] val_mem [MAX_BUCKETS];
    logic [WAYS-1:0]       vld_mem [MAX_BUCKETS];

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_keys  <= key_mem[rd_addr];
            rd_vals  <= val_mem[rd_addr];
            rd_valid <= vld_mem[rd_addr];
        end
        if (wr_en)
        begin
            key_mem[wr_addr][wr_way] <= wr_key;
            val_mem[wr_addr][wr_way] <= wr_val;
        end
        if (vwr_en)
            vld_mem[wr_addr] <= vwr_data;
    end
endmodule

// ===== hdl/sparse_array_hash_store.sv =====
// Sparse array store: each input word is an assign or a read of a signed 64-bit key and
// yields one result word. The bucket is found by a bit-serial remainder of the key by
// bucket_count, then one bucket read, one check and write-back, and one load of the
// output register; the next input is accepted only after the result is loaded.
// One word is in work at a time; a result held by the receiver stalls the input.
// Each bucket has WAYS ways; an insert into a full bucket is dropped with status 1.
// Valid bits sit in a memory that a clearing pass over all MAX_BUCKETS buckets empties
// after reset, before the first input is taken. bucket_count must be written only while
// idle; the block itself does not enforce it. Zero acts as 1, values above MAX_BUCKETS
// as MAX_BUCKETS.
module sparse_array_hash_store #(
    parameter int MAX_BUCKETS = 256,
    parameter int WAYS        = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [127:0]  s_tdata,   // key[63:0], value[127:64]
    input  logic          s_tuser,   // kind
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [63:0]   m_tdata,   // read_value
    output logic          m_tuser,   // status
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [8:0]    cfg_data
);
    import sahs_pkg::*;

    localparam int BW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int WYW = (WAYS > 1) ? $clog2(WAYS) : 1;

    typedef enum logic [2:0] {S_CLR, S_IDLE, S_MOD, S_RD, S_CHK, S_OUT} state_t;

    state_t            state_reg;
    logic [BW-1:0]     clr_reg;
    logic [8:0]        cfg_reg;
    logic              kind_reg;
    logic [63:0]       key_reg;
    logic [63:0]       val_reg;
    logic [BW-1:0]     bkt_reg;
    logic              m_tvalid_reg;
    logic [63:0]       rv_reg;
    logic              st_reg;
    logic [63:0]       res_rv_reg;
    logic              res_st_reg;

    logic [BW:0]       modulus;
    logic              mod_done;
    logic [BW-1:0]     mod_bucket;
    logic [WAYS-1:0][63:0] rd_keys, rd_vals;
    logic              wr_en;
    logic [WYW-1:0]    wr_way;
    logic [WAYS-1:0]   vb;
    logic [WAYS-1:0]   vb_next;
    logic              vwr_en;
    logic [WAYS-1:0]   vwr_data;
    logic [BW-1:0]     bank_addr;
    logic              hit;
    logic [WYW-1:0]    hit_way;
    logic              has_free;
    logic [WYW-1:0]    free_way;

    always_comb
    begin
        if (cfg_reg == 9'd0)
            modulus = (BW+1)'(1);
        else if (32'(cfg_reg) > MAX_BUCKETS)
            modulus = (BW+1)'(MAX_BUCKETS);
        else
            modulus = (BW+1)'(cfg_reg);
    end

    sahs_mod #(.BW(BW)) u_mod (
        .clk(clk), .rst_n(rst_n),
        .start(s_tvalid && s_tready),
        .key(s_tdata[63:0]),
        .modulus(modulus),
        .done(mod_done),
        .bucket(mod_bucket)
    );

    always_comb
    begin
        hit      = 1'b0;
        hit_way  = '0;
        has_free = 1'b0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (vb[w] && rd_keys[w] == key_reg)
            begin
                hit     = 1'b1;
                hit_way = WYW'(w);
            end
            if (!vb[w])
            begin
                has_free = 1'b1;
                free_way = WYW'(w);
            end
        end
    end

    always_comb
    begin
        vb_next = vb;
        if (kind_reg == KIND_ASSIGN)
        begin
            if (val_reg == '0)
            begin
                if (hit)
                    vb_next[hit_way] = 1'b0;
            end
            else if (!hit && has_free)
                vb_next[free_way] = 1'b1;
        end
    end

    assign wr_en = (state_reg == S_CHK) && kind_reg == KIND_ASSIGN && val_reg != '0
                   && (hit || has_free);
    assign wr_way    = hit ? hit_way : free_way;
    assign vwr_en    = (state_reg == S_CLR) || (state_reg == S_CHK);
    assign vwr_data  = (state_reg == S_CLR) ? '0 : vb_next;
    assign bank_addr = (state_reg == S_CLR) ? clr_reg : bkt_reg;

    sahs_bank #(.MAX_BUCKETS(MAX_BUCKETS), .WAYS(WAYS), .BW(BW)) u_bank (
        .clk(clk),
        .rd_en(state_reg == S_RD),
        .rd_addr(bkt_reg),
        .rd_keys(rd_keys),
        .rd_vals(rd_vals),
        .rd_valid(vb),
        .wr_en(wr_en),
        .wr_addr(bank_addr),
        .wr_way(wr_way),
        .wr_key(key_reg),
        .wr_val(val_reg),
        .vwr_en(vwr_en),
        .vwr_data(vwr_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            clr_reg      <= '0;
            cfg_reg      <= 9'd256;
            m_tvalid_reg <= 1'b0;
            kind_reg     <= 1'b0;
            key_reg      <= '0;
            val_reg      <= '0;
            bkt_reg      <= '0;
            rv_reg       <= '0;
            st_reg       <= 1'b0;
            res_rv_reg   <= '0;
            res_st_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                cfg_reg <= cfg_data;
            if (state_reg == S_OUT && (!m_tvalid_reg || m_tready))
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            unique case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + BW'(1);
                    if (clr_reg == BW'(MAX_BUCKETS - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        kind_reg  <= s_tuser;
                        key_reg   <= s_tdata[63:0];
                        val_reg   <= s_tdata[127:64];
                        state_reg <= S_MOD;
                    end
                end
                S_MOD:
                begin
                    if (mod_done)
                    begin
                        bkt_reg   <= mod_bucket;
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                    state_reg <= S_CHK;
                S_CHK:
                begin
                    res_rv_reg <= (kind_reg == KIND_READ && hit) ? rd_vals[hit_way] : '0;
                    res_st_reg <= kind_reg == KIND_ASSIGN && val_reg != '0
                                  && !hit && !has_free;
                    state_reg  <= S_OUT;
                end
                S_OUT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        rv_reg    <= res_rv_reg;
                        st_reg    <= res_st_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = rv_reg;
    assign m_tuser   = st_reg;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped");
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while held");
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == S_MOD)
        else $error("accept did not start work");
    a_read_no_status: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CHK && kind_reg == KIND_READ |=> !res_st_reg)
        else $error("status on read");
endmodule

// ===== tb/tb_sparse_array_hash_store.sv =====
`timescale 1ns / 1ps

module tb_sparse_array_hash_store;
    import sahs_pkg::*;

    localparam int MAXB = 256;
    localparam int NWAYS = 4;
    localparam int NSLOTS = MAXB * NWAYS;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct
    {
        logic [63:0] read_value;
        logic        status;
    } outcome_t;

    class store_scoreboard;
        logic [63:0] slot_key[NSLOTS];
        logic [63:0] slot_val[NSLOTS];
        bit          slot_used[NSLOTS];
        logic [8:0]  buckets;
        outcome_t    pending[$];
        int          errors;

        function new();
            clear();
        endfunction

        function void clear();
            for (int i = 0; i < NSLOTS; i++)
                slot_used[i] = 0;
            buckets = 9'd256;
            pending.delete();
            errors = 0;
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function int bucket_of(logic [63:0] k);
            logic [63:0] m;
            logic [63:0] r;
            m = (buckets == 0) ? 64'd1 : ((buckets > MAXB) ? 64'(MAXB) : 64'(buckets));
            if (k[63])
            begin
                r = (64'd0 - k) % m;
                return (r == 0) ? 0 : int'(m - r);
            end
            return int'(k % m);
        endfunction

        function void note_word(kind_t kd, logic [63:0] k, logic [63:0] v);
            outcome_t o;
            int base;
            int free;
            bit hit;
            o.read_value = '0;
            o.status = 0;
            base = bucket_of(k) * NWAYS;
            free = -1;
            hit = 0;
            for (int w = 0; w < NWAYS && !hit; w++)
            begin
                if (slot_used[base + w] && slot_key[base + w] == k)
                begin
                    hit = 1;
                    if (kd == KIND_READ)
                        o.read_value = slot_val[base + w];
                    else if (v == 0)
                        slot_used[base + w] = 0;
                    else
                        slot_val[base + w] = v;
                end
                else if (!slot_used[base + w] && free < 0)
                    free = base + w;
            end
            if (!hit && kd == KIND_ASSIGN && v != 0)
            begin
                if (free >= 0)
                begin
                    slot_key[free] = k;
                    slot_val[free] = v;
                    slot_used[free] = 1;
                end
                else
                    o.status = 1;
            end
            pending.push_back(o);
        endfunction

        task check_word(logic [63:0] rv, logic st);
            outcome_t o;
            if (pending.size() == 0)
            begin
                report_mismatch("unexpected result word");
                return;
            end
            o = pending.pop_front();
            if (rv !== o.read_value)
                report_mismatch($sformatf("read_value %h want %h", rv, o.read_value));
            if (st !== o.status)
                report_mismatch($sformatf("status %b want %b", st, o.status));
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [127:0] s_tdata = '0;
    logic s_tuser = 0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [63:0] m_tdata;
    logic m_tuser;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [8:0] cfg_data = '0;

    store_scoreboard sb = new();
    int idle_cycles = 0;
    bit rx_quiet = 0;
    bit rx_hold = 0;
    bit rx_long = 0;
    logic [63:0] key_pool[16];

    always #4 clk = ~clk;

    sparse_array_hash_store #(.MAX_BUCKETS(MAXB), .WAYS(NWAYS)) DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    task automatic send_word(kind_t kd, logic [63:0] k, logic [63:0] v, bit gaps);
        if (gaps && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser <= kd;
        s_tdata <= {v, k};
        do @(posedge clk); while (!s_tready);
        sb.note_word(kd, k, v);
    endtask

    task automatic write_buckets(logic [8:0] n);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        cfg_valid <= 1;
        cfg_data <= n;
        do @(posedge clk); while (!cfg_ready);
        sb.buckets = n;
        cfg_valid <= 0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] pick_key();
        case ($urandom_range(0, 3))
            0: return rand64();
            1: return 64'($signed($urandom_range(0, 40)) - 20);
            default: return key_pool[$urandom_range(0, 15)];
        endcase
    endfunction

    task automatic random_phase(int n, bit gaps);
        logic [63:0] v;
        for (int i = 0; i < n; i++)
        begin
            v = ($urandom_range(0, 4) == 0) ? 64'd0 : rand64();
            send_word($urandom_range(0, 1) ? KIND_READ : KIND_ASSIGN, pick_key(), v, gaps);
        end
        s_tvalid <= 0;
    endtask

    // receiver
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_word(m_tdata, m_tuser);
        if (rx_hold || rx_long)
            m_tready <= 0;
        else if (rx_quiet)
            m_tready <= 1;
        else
            m_tready <= ($urandom_range(0, 5) != 0);
    end

    // burst stalls
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!rx_quiet && $urandom_range(0, 30) == 0)
            begin
                rx_hold = 1;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                rx_hold = 0;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < 16; i++)
            key_pool[i] = (i < 8) ? 64'($signed(i * 7 - 24)) : rand64();
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, delete, full bucket, negative keys
        send_word(KIND_READ, 64'h8000_0000_0000_0000, 64'd5, 0);
        send_word(KIND_ASSIGN, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 0);
        send_word(KIND_ASSIGN, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 0);
        send_word(KIND_READ, 64'h8000_0000_0000_0000, 64'd0, 0);
        send_word(KIND_READ, 64'h7FFF_FFFF_FFFF_FFFF, '1, 0);
        send_word(KIND_ASSIGN, 64'd99, 64'd0, 0);
        send_word(KIND_ASSIGN, -64'd1, 64'd3, 0);
        send_word(KIND_ASSIGN, -64'd1, '1, 0);
        send_word(KIND_READ, -64'd1, 64'd0, 0);
        send_word(KIND_ASSIGN, -64'd1, 64'd0, 0);
        send_word(KIND_READ, -64'd1, 64'd0, 0);
        for (int i = 0; i < 6; i++)
            send_word(KIND_ASSIGN, 64'(i * 256 + 5), 64'(i + 1), 0);
        send_word(KIND_READ, 64'(4 * 256 + 5), 64'd0, 0);
        send_word(KIND_ASSIGN, 64'd5, 64'd0, 0);
        send_word(KIND_ASSIGN, 64'(5 * 256 + 5), 64'd9, 0);
        send_word(KIND_READ, 64'(5 * 256 + 5), 64'd0, 0);

        // long receiver hold so the block backs up
        rx_long = 1;
        fork
            begin
                repeat (600) @(posedge clk);
                rx_long = 0;
            end
            random_phase(6, 0);
        join

        write_buckets(9'd0);
        random_phase(150, 1);
        write_buckets(9'd1);
        random_phase(100, 1);
        write_buckets(9'd3);
        random_phase(300, 1);
        write_buckets(9'd511);
        random_phase(200, 1);
        write_buckets(9'd256);
        random_phase(200, 1);
        write_buckets(9'd257);
        random_phase(150, 1);
        write_buckets(9'd7);
        random_phase(300, 1);
        rx_quiet = 1;
        random_phase(250, 0);

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
